@@ rtl/core/decimal_string_to_fixed_point_defines.svh @@
// Assertion helpers shared by the RTL; they sample on clk and stay quiet in rst.
`ifndef DECIMAL_STRING_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_DEFINES_SVH

// Same-cycle implication.
`define DSTFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DSTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dstfp_pkg.sv @@
`default_nettype none

package dstfp_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 64;
  localparam int FD_W                = 5;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 32;

  localparam logic [FD_W-1:0] FRACTION_DIGITS_RESET = 5'd6;
  // largest exponent held in the 64-bit power-of-ten constant table
  localparam logic [FD_W-1:0] MAX_POW_EXP           = 5'd18;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NO_DIGITS   = 3'd2,
    ST_MANY_POINTS = 3'd3,
    ST_INVALID     = 3'd4,
    ST_MANY_PLACES = 3'd5,
    ST_RANGE       = 3'd6,
    ST_NO_PERCENT  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_BODY  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  typedef enum logic {
    REG_FRACTION_DIGITS = 1'b0,
    REG_PERCENT_MODE    = 1'b1
  } cfg_reg_t;

  // Powers of ten up to 10^18; larger exponents are handled as overflow by the caller.
  function automatic logic [63:0] pow10(input logic [FD_W-1:0] e);
    logic [63:0] p;
    case (e)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dstfp_char_if.sv @@
`default_nettype none

interface dstfp_char_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output has_char, output ch, output last, input ready);
  modport sink   (input valid, input has_char, input ch, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dstfp_result_if.sv @@
`default_nettype none

interface dstfp_result_if #(
  parameter int VALUE_WIDTH = dstfp_pkg::VALUE_WIDTH_DEFAULT
);
  import dstfp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  status_t                       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/decimal_string_to_fixed_point.sv @@
// Streaming ASCII decimal parser: one character per clock in, one signed fixed-point
// result (value scaled by ten to fraction_digits, plus status) per string out. A string
// ends on the item with last set; its result enters a two-entry output buffer when
// that item leaves the input register, so a new character is taken every cycle while a
// finished result waits; only a string end that finds both entries full holds the input.
// The sustained rate of one character per cycle is set by the parse stage, which folds
// each digit into the magnitude (times ten plus digit) and into the padded scaled value
// (times ten plus digit times a power of ten; after the point only the digit term is added).
// Configure fraction_digits (reg 0, reset 6) and percent_mode (reg 1) only while idle.
`default_nettype none
`include "decimal_string_to_fixed_point_defines.svh"

module decimal_string_to_fixed_point #(
  parameter int VALUE_WIDTH = dstfp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dstfp_char_if.sink                             char_stream,
  dstfp_result_if.source                         result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dstfp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [dstfp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [dstfp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                   pready
);
  import dstfp_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int MW = VALUE_WIDTH + 4;
  localparam int AW = ((VALUE_WIDTH + 4 > 64) ? VALUE_WIDTH + 4 : 64) + 1;

  // ---------------- configuration ----------------
  logic [FD_W-1:0] fraction_digits;
  logic            percent_mode;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= FRACTION_DIGITS_RESET;
      percent_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(paddr[2]))
        REG_FRACTION_DIGITS: fraction_digits <= pwdata[FD_W-1:0];
        REG_PERCENT_MODE:    percent_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_FRACTION_DIGITS: prdata = CFG_DATA_W'(fraction_digits);
      REG_PERCENT_MODE:    prdata = CFG_DATA_W'(percent_mode);
      default:             prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic       s1_valid;
  logic       s1_has;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic       s1_adv;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign s1_adv            = s1_valid && (!s1_last || cnt != 2'd2);
  assign char_stream.ready = !s1_valid || s1_adv;
  assign push              = s1_adv && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_stream.ready) begin
      s1_valid <= char_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_stream.ready && char_stream.valid) begin
      s1_has  <= char_stream.has_char;
      s1_ch   <= char_stream.ch;
      s1_last <= char_stream.last;
    end
  end

  // ---------------- parse state ----------------
  logic [W-1:0]    mag, mag_next;
  logic [W-1:0]    scaled, scaled_next;
  logic            pad_ovf, pad_ovf_next;
  logic            neg, neg_next;
  logic            seen_point, seen_point_next;
  logic            seen_digit, seen_digit_next;
  logic [FD_W-1:0] places, places_next;
  phase_t          phase, phase_next;
  logic            pct_pend, pct_pend_next;
  status_t         first_err, first_err_next;

  logic [3:0]      digit;
  logic [W-1:0]    lim;
  logic [MW-1:0]   mag_x, mag_sum;
  logic [FD_W-1:0] exp_sel;
  logic [63:0]     pow, term;
  logic            big_term;
  logic [AW-1:0]   sc_x, sc_base, sc_sum;
  logic            is_space, is_digit, is_pct;

  assign digit = s1_ch[3:0];
  assign lim   = {1'b0, {(W-1){1'b1}}} + W'(neg);

  // magnitude times ten plus digit
  assign mag_x   = MW'(mag);
  assign mag_sum = (mag_x << 3) + (mag_x << 1) + MW'(digit);

  // scaled value: integer digit shifts by ten, fraction digit adds at its own place
  assign exp_sel  = seen_point ? (fraction_digits - places - 5'd1) : fraction_digits;
  assign pow      = pow10(exp_sel);
  assign term     = (digit[0] ? pow : 64'd0) + (digit[1] ? (pow << 1) : 64'd0)
                  + (digit[2] ? (pow << 2) : 64'd0) + (digit[3] ? (pow << 3) : 64'd0);
  assign big_term = (exp_sel > MAX_POW_EXP) && (digit != 4'd0);
  assign sc_x     = AW'(scaled);
  assign sc_base  = seen_point ? sc_x : ((sc_x << 3) + (sc_x << 1));
  assign sc_sum   = sc_base + AW'(term);

  always_comb begin
    is_space = s1_ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    is_digit = s1_ch inside {[CH_ZERO:CH_NINE]};
    is_pct   = percent_mode && (s1_ch == CH_PERCENT);

    mag_next        = mag;
    scaled_next     = scaled;
    pad_ovf_next    = pad_ovf;
    neg_next        = neg;
    seen_point_next = seen_point;
    seen_digit_next = seen_digit;
    places_next     = places;
    phase_next      = phase;
    pct_pend_next   = pct_pend;
    first_err_next  = first_err;

    if (s1_has) begin
      if (is_space) begin
        if (first_err == ST_OK && !pct_pend && phase == PH_BODY) begin
          phase_next = PH_TRAIL;
        end
      end else if (first_err != ST_OK) begin
        pct_pend_next = is_pct;
      end else if (pct_pend) begin
        // percent sign that is not the last non-space character
        first_err_next = ST_INVALID;
        pct_pend_next  = is_pct;
      end else if (is_pct) begin
        pct_pend_next = 1'b1;
      end else if (phase == PH_TRAIL) begin
        first_err_next = ST_INVALID;
      end else if (phase == PH_LEAD && (s1_ch == CH_PLUS || s1_ch == CH_MINUS)) begin
        phase_next = PH_BODY;
        neg_next   = (s1_ch == CH_MINUS);
      end else begin
        phase_next = PH_BODY;
        if (s1_ch == CH_POINT) begin
          if (seen_point) first_err_next = ST_MANY_POINTS;
          else            seen_point_next = 1'b1;
        end else if (!is_digit) begin
          first_err_next = ST_INVALID;
        end else begin
          seen_digit_next = 1'b1;
          if (seen_point && places >= fraction_digits) begin
            first_err_next = ST_MANY_PLACES;
          end else begin
            if (seen_point) places_next = places + 5'd1;
            if (mag_sum > MW'(lim)) begin
              first_err_next = ST_RANGE;
            end else begin
              mag_next = mag_sum[W-1:0];
              if (!pad_ovf) begin
                // sticky: padding to fraction_digits would not fit
                if (big_term || sc_sum > AW'(lim)) pad_ovf_next = 1'b1;
                else                               scaled_next  = sc_sum[W-1:0];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      mag        <= '0;
      scaled     <= '0;
      pad_ovf    <= 1'b0;
      neg        <= 1'b0;
      seen_point <= 1'b0;
      seen_digit <= 1'b0;
      places     <= '0;
      phase      <= PH_LEAD;
      pct_pend   <= 1'b0;
      first_err  <= ST_OK;
    end else if (s1_adv) begin
      mag        <= mag_next;
      scaled     <= scaled_next;
      pad_ovf    <= pad_ovf_next;
      neg        <= neg_next;
      seen_point <= seen_point_next;
      seen_digit <= seen_digit_next;
      places     <= places_next;
      phase      <= phase_next;
      pct_pend   <= pct_pend_next;
      first_err  <= first_err_next;
    end
  end

  // ---------------- finish ----------------
  status_t      fin_status;
  logic [W-1:0] fin_value;

  always_comb begin
    fin_value = '0;
    if (percent_mode && !pct_pend_next) begin
      fin_status = ST_NO_PERCENT;
    end else if (first_err_next != ST_OK) begin
      fin_status = first_err_next;
    end else if (phase_next == PH_LEAD) begin
      fin_status = ST_EMPTY;
    end else if (!seen_digit_next) begin
      fin_status = ST_NO_DIGITS;
    end else if (pad_ovf_next) begin
      fin_status = ST_RANGE;
    end else begin
      fin_status = ST_OK;
      fin_value  = neg_next ? (W'(0) - scaled_next) : scaled_next;
    end
  end

  // ---------------- two-entry result buffer ----------------
  logic [W-1:0] head_value, tail_value;
  status_t      head_status, tail_status;

  assign pop           = (cnt != 2'd0) && result.ready;
  assign result.valid  = (cnt != 2'd0);
  assign result.value  = head_value;
  assign result.status = head_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      head_value  <= tail_value;
      head_status <= tail_status;
    end else if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      head_value  <= fin_value;
      head_status <= fin_status;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      tail_value  <= fin_value;
      tail_status <= fin_status;
    end
  end

  // ---------------- assertions ----------------
  `DSTFP_ASSERT_IMP(a_err_value_zero, result.valid && result.status != ST_OK, result.value == '0, "error result carries a nonzero value")
  `DSTFP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt != 2'd3, "result buffer count out of range")
  `DSTFP_ASSERT_NEXT(a_push_visible, push, cnt != 2'd0, "finished result not held in buffer")
  `DSTFP_ASSERT_NEXT(a_clear_after_last, push, phase == PH_LEAD && first_err == ST_OK && !pct_pend, "parse state not cleared after string end")

endmodule

`default_nettype wire
